### src/ppp_afe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppp_afe_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [7:0]  ADDR_BYTE = 8'hFF;
   localparam logic [7:0]  CTRL_BYTE = 8'h03;
   localparam logic [15:0] IP_PROTO  = 16'h0021;
   localparam logic [15:0] FCS_SEED  = 16'hFFFF;
   localparam logic [15:0] FCS_POLY  = 16'h8408;

   localparam int SLOT_COUNT = 5;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2,
      KIND_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_ACCM_0   = 3'd0,
      CSR_ACCM_1   = 3'd1,
      CSR_ACCM_2   = 3'd2,
      CSR_ACCM_3   = 3'd3,
      CSR_PFC      = 3'd4,
      CSR_ACFC     = 3'd5,
      CSR_UNUSED_6 = 3'd6,
      CSR_UNUSED_7 = 3'd7
   } csr_index_type;

   localparam logic [63:0] ACCM_0_RESET = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] ACCM_1_RESET = 64'h6000_0000_0000_0000;
   localparam logic [63:0] ACCM_2_RESET = 64'h0;
   localparam logic [63:0] ACCM_3_RESET = 64'h0;

   typedef struct packed {
      logic pfc_enable;
      logic acfc_enable;
   } cfg_flags_type;

   // Reflected CCITT FCS-16, one byte folded in eight bit steps.
   function automatic logic [15:0] fcs_fold(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] v;
      v = fcs ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (v[0]) begin
            v = (v >> 1) ^ FCS_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### src/ppp_afe_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module ppp_afe_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [63:0]                csr_write_data,
   input  wire logic [7:0]                 lookup_byte,
   output logic                            lookup_escape,
   output ppp_afe_pkg::cfg_flags_type      cfg_flags
);
   import ppp_afe_pkg::*;

   logic [63:0]   accm_0_ff, accm_1_ff, accm_2_ff, accm_3_ff;
   cfg_flags_type flags_ff;
   logic [63:0]   accm_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         accm_0_ff <= ACCM_0_RESET;
         accm_1_ff <= ACCM_1_RESET;
         accm_2_ff <= ACCM_2_RESET;
         accm_3_ff <= ACCM_3_RESET;
         flags_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ACCM_0: accm_0_ff <= csr_write_data;
            CSR_ACCM_1: accm_1_ff <= csr_write_data;
            CSR_ACCM_2: accm_2_ff <= csr_write_data;
            CSR_ACCM_3: accm_3_ff <= csr_write_data;
            CSR_PFC:    flags_ff.pfc_enable  <= csr_write_data[0];
            CSR_ACFC:   flags_ff.acfc_enable <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (lookup_byte[7:6])
         2'd0:    accm_word = accm_0_ff;
         2'd1:    accm_word = accm_1_ff;
         2'd2:    accm_word = accm_2_ff;
         default: accm_word = accm_3_ff;
      endcase
   end

   assign lookup_escape = accm_word[lookup_byte[5:0]];
   assign cfg_flags     = flags_ff;

endmodule

`default_nettype wire

### src/ppp_afe_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ppp_afe_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [15:0]             req_protocol_number,
   input  wire logic [7:0]              req_data_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last_of_run,
   input  wire ppp_afe_pkg::cfg_flags_type cfg_flags,
   output logic [7:0]                   lookup_byte,
   input  wire logic                    lookup_escape
);
   import ppp_afe_pkg::*;

   // Slots of one item: opening flag, address, control, protocol high, protocol
   // low. A payload byte uses the last slot; an end item uses the middle three
   // for the FCS low byte, the FCS high byte and the closing flag.
   logic [SLOT_COUNT-1:0] pend_ff, pend_in;
   logic                  end_ff, end_in;
   logic [7:0]            hi_ff, hi_in;
   logic [7:0]            lo_ff, lo_in;
   logic                  esc_ff, esc_in;
   logic [15:0]           fcs_ff, fcs_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [2:0]            cur_slot;
   logic [SLOT_COUNT-1:0] others;
   logic                  is_last;
   logic [7:0]            cur_byte;
   logic                  is_raw;
   logic                  do_fold;
   logic                  esc_need;
   logic                  out_free;
   logic                  step;
   logic                  byte_done;
   logic                  is_ip;
   logic [SLOT_COUNT-1:0] load_mask;
   req_kind_type          kind;

   always_comb begin
      cur_slot = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            cur_slot = 3'(i);
         end
      end
   end

   assign others  = pend_ff & ~(SLOT_COUNT'(1) << cur_slot);
   assign is_last = (others == '0);

   always_comb begin
      case (cur_slot)
         3'd0:    cur_byte = FLAG_BYTE;
         3'd1:    cur_byte = end_ff ? ~fcs_ff[7:0]  : ADDR_BYTE;
         3'd2:    cur_byte = end_ff ? ~fcs_ff[15:8] : CTRL_BYTE;
         3'd3:    cur_byte = end_ff ? FLAG_BYTE     : hi_ff;
         default: cur_byte = lo_ff;
      endcase
   end

   assign is_raw      = (cur_slot == 3'd0) || (end_ff && cur_slot == 3'd3);
   assign do_fold     = !end_ff && !is_raw;
   assign lookup_byte = cur_byte;
   assign esc_need    = !is_raw && lookup_escape;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = (pend_ff != '0) && out_free;
   assign byte_done = step && (!esc_need || esc_ff);
   assign req_ready = (pend_ff == '0) || (byte_done && is_last);

   assign kind  = req_kind_type'(req_type);
   assign is_ip = (req_protocol_number == IP_PROTO);

   always_comb begin
      case (kind)
         KIND_HEADER: begin
            load_mask[0] = 1'b1;
            load_mask[1] = !(is_ip && cfg_flags.acfc_enable);
            load_mask[2] = !(is_ip && cfg_flags.acfc_enable);
            load_mask[3] = !(is_ip && cfg_flags.pfc_enable);
            load_mask[4] = 1'b1;
         end
         KIND_PAYLOAD: load_mask = 5'b10000;
         KIND_END:     load_mask = 5'b01110;
         default:      load_mask = '0;
      endcase
   end

   always_comb begin
      pend_in      = pend_ff;
      end_in       = end_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      esc_in       = esc_ff;
      fcs_in       = fcs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = byte_done && is_last;
         if (esc_need && !esc_ff) begin
            rsp_byte_in = ESC_BYTE;
            esc_in      = 1'b1;
         end else begin
            rsp_byte_in = esc_need ? (cur_byte ^ ESC_XOR) : cur_byte;
         end
      end

      if (byte_done) begin
         pend_in = others;
         esc_in  = 1'b0;
         if (do_fold) begin
            fcs_in = fcs_fold(fcs_ff, cur_byte);
         end
         if (end_ff && is_last) begin
            fcs_in = FCS_SEED;
         end
      end

      if (req_valid && req_ready && kind != KIND_NONE) begin
         pend_in = load_mask;
         end_in  = (kind == KIND_END);
         hi_in   = req_protocol_number[15:8];
         lo_in   = (kind == KIND_PAYLOAD) ? req_data_byte : req_protocol_number[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         esc_ff       <= 1'b0;
         fcs_ff       <= FCS_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         esc_ff       <= esc_in;
         fcs_ff       <= fcs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_ff      <= end_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

### src/ppp_async_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// PPP asynchronous framer: an accepted req_ item is loaded into the slot register,
// and its first line byte then goes to the rsp_ output register. One line byte
// leaves per cycle while rsp_ready allows. An item makes 2 to 9 line bytes for a
// header, 1 or 2 for a payload byte, 3 to 5 for a frame end; the next item is
// taken as its last byte leaves. Synchronous reset clears the pipeline, sets the
// FCS to 0xFFFF and the escape map and compression flags to their defaults.

module ppp_async_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_protocol_number,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);
   import ppp_afe_pkg::*;

   cfg_flags_type cfg_flags;
   logic [7:0]    lookup_byte;
   logic          lookup_escape;

   ppp_afe_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .lookup_byte      (lookup_byte),
      .lookup_escape    (lookup_escape),
      .cfg_flags        (cfg_flags)
   );

   ppp_afe_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_protocol_number (req_protocol_number),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_run     (rsp_last_of_run),
      .cfg_flags           (cfg_flags),
      .lookup_byte         (lookup_byte),
      .lookup_escape       (lookup_escape)
   );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import ppp_afe_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } line_byte_type;

   // Tracks the transmit framer: escape map, compression flags and running FCS,
   // plus the line bytes still owed by the block.
   class line_byte_tracker;
      logic [63:0]   escape_map [4];
      logic          drop_proto_high;
      logic          drop_addr_ctrl;
      logic [15:0]   fcs;
      line_byte_type owed_bytes [$];
      int            mismatches;
      int            bytes_checked;
      int            escapes_made;
      int            frames_closed;

      function new();
         escape_map[0] = ACCM_0_RESET;
         escape_map[1] = ACCM_1_RESET;
         escape_map[2] = ACCM_2_RESET;
         escape_map[3] = ACCM_3_RESET;
         drop_proto_high = 1'b0;
         drop_addr_ctrl = 1'b0;
         fcs = FCS_SEED;
      endfunction

      function void set_register(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_ACCM_0: escape_map[0] = value;
            CSR_ACCM_1: escape_map[1] = value;
            CSR_ACCM_2: escape_map[2] = value;
            CSR_ACCM_3: escape_map[3] = value;
            CSR_PFC:    drop_proto_high = value[0];
            CSR_ACFC:   drop_addr_ctrl = value[0];
            default: ;
         endcase
      endfunction

      // Reflected CCITT FCS-16, shifting one data bit at a time, LSB first.
      function logic [15:0] fold_fcs16(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
               c = {1'b0, c[15:1]} ^ FCS_POLY;
            end else begin
               c = {1'b0, c[15:1]};
            end
         end
         return c;
      endfunction

      function void push_raw(logic [7:0] b);
         owed_bytes.push_back('{value: b, last: 1'b0});
      endfunction

      function void push_escaped(logic [7:0] b);
         if (escape_map[b[7:6]][b[5:0]]) begin
            push_raw(ESC_BYTE);
            push_raw(b ^ ESC_XOR);
            escapes_made++;
         end else begin
            push_raw(b);
         end
      endfunction

      function void push_folded(logic [7:0] b);
         fcs = fold_fcs16(fcs, b);
         push_escaped(b);
      endfunction

      function void note_item(logic [1:0] kind, logic [15:0] proto, logic [7:0] data);
         logic        is_ip;
         logic [15:0] sent_fcs;
         is_ip = (proto == IP_PROTO);
         case (kind)
            KIND_HEADER: begin
               push_raw(FLAG_BYTE);
               if (!(is_ip && drop_addr_ctrl)) begin
                  push_folded(ADDR_BYTE);
                  push_folded(CTRL_BYTE);
               end
               // For IP the high byte is zero, so only the flag decides.
               if (!(is_ip && drop_proto_high)) begin
                  push_folded(proto[15:8]);
               end
               push_folded(proto[7:0]);
            end
            KIND_PAYLOAD: begin
               push_folded(data);
            end
            KIND_END: begin
               sent_fcs = fcs ^ FCS_SEED;
               push_escaped(sent_fcs[7:0]);
               push_escaped(sent_fcs[15:8]);
               push_raw(FLAG_BYTE);
               fcs = FCS_SEED;
               frames_closed++;
            end
            default: return;
         endcase
         owed_bytes[owed_bytes.size() - 1].last = 1'b1;
      endfunction

      function void check_line_byte(logic [7:0] value, logic last);
         line_byte_type want;
         if (owed_bytes.size() == 0) begin
            $error("line byte %h with nothing owed", value);
            mismatches++;
            return;
         end
         want = owed_bytes.pop_front();
         bytes_checked++;
         if (value !== want.value) begin
            $error("out_byte: expected %h, got %h", want.value, value);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, last);
            mismatches++;
         end
      endfunction

      function int owed_count();
         return owed_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = KIND_NONE;
   logic [15:0] req_protocol_number = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = CSR_ACCM_0;
   logic [63:0] csr_write_data = '0;

   line_byte_tracker tracker;
   int items_sent = 0;
   int send_idle_pct = 34;
   int recv_idle_pct = 80;

   ppp_async_frame_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_protocol_number(req_protocol_number),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Outputs are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && tracker != null) begin
         tracker.check_line_byte(rsp_out_byte, rsp_last_of_run);
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic [1:0] kind, logic [15:0] proto, logic [7:0] data);
      send_idle_pct = (items_sent < 150) ? 34 : (items_sent < 300) ? 80 : 0;
      recv_idle_pct = (items_sent < 150) ? 80 : (items_sent < 300) ? 34 : 0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_protocol_number <= proto;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_item(kind, proto, data);
      if (kind != KIND_NONE) begin
         items_sent++;
      end
   endtask

   // Holds the sender off until every owed byte is out and the block settles.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.owed_count() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                               logic [63:0] m3, logic pfc, logic acfc);
      csr_index_type order [7];
      logic [63:0]   values [7];
      order = '{CSR_ACCM_0, CSR_ACCM_1, CSR_ACCM_2, CSR_ACCM_3, CSR_PFC, CSR_ACFC,
                CSR_UNUSED_6};
      // Flag writes carry junk above bit 0; the unused index must change nothing.
      values = '{m0, m1, m2, m3, {31'($urandom), 32'($urandom), pfc},
                 {31'($urandom), 32'($urandom), acfc}, {32'($urandom), 32'($urandom)}};
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= order[i];
         csr_write_data <= values[i];
         @(posedge clock);
         tracker.set_register(order[i], values[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(int item_target);
      int          stop_at;
      int          len;
      int          pick;
      logic [15:0] proto;
      logic [7:0]  data;
      stop_at = items_sent + item_target;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               proto = IP_PROTO;
            end else if (pick < 50) begin
               proto = {8'h00, 8'($urandom)};
            end else if (pick < 60) begin
               proto = {8'($urandom), IP_PROTO[7:0]};
            end else begin
               proto = 16'($urandom);
            end
            send_item(KIND_HEADER, proto, 8'($urandom));
            len = $urandom_range(10);
            repeat (len) begin
               case ($urandom_range(7))
                  0: data = FLAG_BYTE;
                  1: data = ESC_BYTE;
                  2: data = 8'($urandom_range(31));
                  default: data = 8'($urandom);
               endcase
               send_item(KIND_PAYLOAD, 16'($urandom), data);
            end
            // Now and then the frame stays open and the next header lands inside it.
            if ($urandom_range(9) != 0) begin
               send_item(KIND_END, 16'($urandom), 8'($urandom));
            end
         end else begin
            send_item(2'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset escape map: control characters, flag and escape are escaped.
      send_item(KIND_HEADER, IP_PROTO, 8'h00);
      send_item(KIND_PAYLOAD, 16'h0000, 8'h00);
      send_item(KIND_PAYLOAD, 16'hFFFF, FLAG_BYTE);
      send_item(KIND_PAYLOAD, 16'h0000, ESC_BYTE);
      send_item(KIND_PAYLOAD, 16'hFFFF, 8'hFF);
      send_item(KIND_PAYLOAD, 16'h0000, 8'h1F);
      send_item(KIND_END, 16'h0000, 8'h00);
      send_item(KIND_HEADER, 16'hFFFF, 8'hFF);
      send_item(KIND_NONE, 16'hFFFF, 8'hFF);
      send_item(KIND_PAYLOAD, 16'h0000, 8'h80);
      send_item(KIND_HEADER, 16'h00C0, 8'h00);
      send_item(KIND_END, 16'hFFFF, 8'hFF);
      send_item(KIND_PAYLOAD, 16'h0000, 8'h55);
      send_item(KIND_END, 16'h0000, 8'h00);
      send_item(KIND_END, 16'h0000, 8'h00);
      send_item(KIND_HEADER, 16'h0000, 8'h00);
      drain();

      // Nothing escaped, both compressions on.
      write_config(64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 1'b1);
      send_item(KIND_HEADER, IP_PROTO, 8'h00);
      send_item(KIND_PAYLOAD, 16'h0000, FLAG_BYTE);
      send_item(KIND_END, 16'h0000, 8'h00);
      send_item(KIND_HEADER, 16'h0121, 8'h00);
      send_item(KIND_END, 16'h0000, 8'h00);
      run_random(88);
      drain();

      write_config('1, '1, '1, '1, 1'b1, 1'b0);
      run_random(88);
      drain();

      write_config({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)},
                   1'b0, 1'b1);
      run_random(88);
      drain();

      write_config(ACCM_0_RESET, ACCM_1_RESET, ACCM_2_RESET, ACCM_3_RESET, 1'b0, 1'b0);
      run_random(88);
      drain();

      write_config({32'($urandom), 32'($urandom)} & {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)} & {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)} & {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)} & {32'($urandom), 32'($urandom)},
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      run_random(88);
      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d items under six escape map and compression settings.", items_sent);
      $display("Checked %0d line bytes, %0d of them escape pairs, in %0d closed frames.",
               tracker.bytes_checked, tracker.escapes_made, tracker.frames_closed);
      if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
